[rtl/bmd_pkg.sv]
// Package for the banked memory decoder: codes, address map constants,
// command and response structs. No dependencies.
package bmd_pkg;

   localparam int OS_ROM_DEPTH_DEF    = 16384;
   localparam int BASIC_ROM_DEPTH_DEF = 8192;
   localparam int RAM_DEPTH           = 65536;
   localparam int RAM_AW              = 16;
   localparam int CMD_FIFO_DEPTH      = 2;
   localparam int RSP_FIFO_DEPTH      = 4;

   localparam logic [15:0] SERIAL_VECTOR  = 16'hE459;
   localparam logic [15:0] SERIAL_RET_PC  = 16'hE45A;
   localparam logic [15:0] ADDR_OS_FIXED  = 16'hD800;
   localparam logic [7:0]  RTS_OPCODE     = 8'h60;
   localparam logic [7:0]  BYTE_ONES      = 8'hFF;

   // PIA control register bit that selects data (1) or direction (0)
   localparam int PIA_CTL_DATA_BIT = 2;
   // port B banking bits
   localparam int PB_OS_BIT       = 0;
   localparam int PB_BASIC_BIT    = 1;
   localparam int PB_SELFTEST_BIT = 7;

   typedef enum logic [1:0] {
      REQ_CPU_RD   = 2'd0,
      REQ_CPU_WR   = 2'd1,
      REQ_DMA_RD   = 2'd2,
      REQ_ROM_LOAD = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      DEV_INTERNAL = 2'd0,
      DEV_VIDEO    = 2'd1,
      DEV_SOUND    = 2'd2,
      DEV_DISPLAY  = 2'd3
   } dev_type;

   typedef enum logic [2:0] {
      RG_LOW,      // 0000-BFFF
      RG_C000,     // C000-CFFF
      RG_VIDEO,    // page D000
      RG_SOUND,    // page D200
      RG_PIA,      // page D300
      RG_DISPLAY,  // page D400
      RG_NONE,     // page D100, D500-D7FF
      RG_HIGH      // D800-FFFF
   } region_type;

   typedef enum logic [1:0] {
      PIA_PORT_A = 2'd0,
      PIA_PORT_B = 2'd1,
      PIA_CTL_A  = 2'd2,
      PIA_CTL_B  = 2'd3
   } pia_reg_type;

   typedef enum logic [1:0] {
      SRC_CONST,
      SRC_RAM,
      SRC_OS,
      SRC_BASIC
   } src_type;

   typedef enum logic {
      CSR_BANKED_MODEL  = 1'b0,
      CSR_BASIC_PRESENT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic banked_model;
      logic basic_present;
   } cfg_type;

   typedef struct packed {
      req_kind_type kind;
      region_type   region;
      logic         vec_hit;
      logic         basic_win;
      logic         selftest_win;
      logic         io_win;
      logic         load_os;
      logic         load_basic;
      logic [4:0]   offset;
      logic [15:0]  address;
      logic [7:0]   write_data;
      logic [7:0]   stick_bits;
   } cmd_type;

   typedef struct packed {
      logic [7:0] read_data;
      dev_type    device_select;
      logic [4:0] device_offset;
      logic       device_write;
      logic       serial_trap;
   } rsp_type;

endpackage

[rtl/bmd_fifo.sv]
// Small synchronous queue with push/full and pop/empty sides and a fill count.
// Stand-alone; no package needed.
module bmd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic [CW-1:0]    count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/bmd_front.sv]
// Front end: accepts bus requests, classifies the address and queues the
// decoded command. Uses bmd_pkg and bmd_fifo.
module bmd_front #(
   parameter int OS_ROM_DEPTH    = bmd_pkg::OS_ROM_DEPTH_DEF,
   parameter int BASIC_ROM_DEPTH = bmd_pkg::BASIC_ROM_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [1:0]       req_type,
   input  logic [15:0]      req_address,
   input  logic [7:0]       req_write_data,
   input  logic [15:0]      req_fetch_pc,
   input  logic [7:0]       req_stick_bits,
   input  logic             hold,
   output bmd_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);
   import bmd_pkg::*;

   localparam int CMD_CW = $clog2(CMD_FIFO_DEPTH + 1);

   cmd_type             cmd_d;
   logic [$bits(cmd_type)-1:0] cmd_q;
   logic                cmd_full, cmd_empty;
   logic [CMD_CW-1:0]   cmd_count;
   logic [16:0]         addr_ext;

   assign addr_ext = {1'b0, req_address};

   always_comb begin
      cmd_d              = '0;
      cmd_d.kind         = req_kind_type'(req_type);
      cmd_d.address      = req_address;
      cmd_d.write_data   = req_write_data;
      cmd_d.stick_bits   = req_stick_bits;
      cmd_d.vec_hit      = (req_address == SERIAL_VECTOR) && (req_fetch_pc == SERIAL_RET_PC);
      cmd_d.basic_win    = (req_address[15:13] == 3'b101);
      cmd_d.selftest_win = (req_address[15:11] == 5'b01010);
      cmd_d.io_win       = (req_address[15:11] == 5'b11010);
      cmd_d.load_os      = (addr_ext < 17'(OS_ROM_DEPTH));
      cmd_d.load_basic   = !cmd_d.load_os &&
                           (addr_ext < 17'(OS_ROM_DEPTH + BASIC_ROM_DEPTH));
      if (req_address[15:14] != 2'b11) begin
         cmd_d.region = RG_LOW;
      end else if (req_address[13:12] == 2'b00) begin
         cmd_d.region = RG_C000;
      end else if (req_address >= ADDR_OS_FIXED) begin
         cmd_d.region = RG_HIGH;
      end else begin
         case (req_address[10:8])
            3'd0: begin
               cmd_d.region = RG_VIDEO;
               cmd_d.offset = req_address[4:0];
            end
            3'd2: begin
               cmd_d.region = RG_SOUND;
               cmd_d.offset = {1'b0, req_address[3:0]};
            end
            3'd3: cmd_d.region = RG_PIA;
            3'd4: begin
               cmd_d.region = RG_DISPLAY;
               cmd_d.offset = {1'b0, req_address[3:0]};
            end
            default: cmd_d.region = RG_NONE;
         endcase
      end
   end

   bmd_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (CMD_FIFO_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push && !hold),
      .push_data (cmd_d),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_q),
      .empty     (cmd_empty),
      .count     (cmd_count)
   );

   // a full queue never reports a count below its depth
   assign full      = cmd_full || hold || (cmd_count == CMD_CW'(CMD_FIFO_DEPTH));
   assign cmd       = cmd_type'(cmd_q);
   assign cmd_valid = !cmd_empty;

endmodule

[rtl/bmd_back.sv]
// Back end: RAM, ROM images, PIA and banking state; executes queued commands
// and buffers responses. Uses bmd_pkg and bmd_fifo.
module bmd_back #(
   parameter int OS_ROM_DEPTH    = bmd_pkg::OS_ROM_DEPTH_DEF,
   parameter int BASIC_ROM_DEPTH = bmd_pkg::BASIC_ROM_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  bmd_pkg::cfg_type cfg,
   input  bmd_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   output logic             clearing,
   output bmd_pkg::rsp_type rsp,
   output logic             rsp_empty,
   input  logic             rsp_pop
);
   import bmd_pkg::*;

   localparam int OS_AW  = $clog2(OS_ROM_DEPTH);
   localparam int BAS_AW = $clog2(BASIC_ROM_DEPTH);
   localparam int RSP_CW = $clog2(RSP_FIFO_DEPTH + 1);

   logic [7:0] main_ram_ff  [RAM_DEPTH];
   logic [7:0] os_rom_ff    [OS_ROM_DEPTH];
   logic [7:0] basic_rom_ff [BASIC_ROM_DEPTH];

   logic [7:0] ram_q_ff, os_q_ff, basic_q_ff;

   logic              clear_ff, clear_in;
   logic [RAM_AW-1:0] clear_addr_ff, clear_addr_in;

   logic [7:0] port_b_out_ff, port_b_out_in;
   logic [7:0] port_a_dir_ff, port_a_dir_in;
   logic [7:0] port_b_dir_ff, port_b_dir_in;
   logic [7:0] port_a_ctl_ff, port_a_ctl_in;
   logic [7:0] port_b_ctl_ff, port_b_ctl_in;
   logic       os_mapped_ff, os_mapped_in;
   logic       basic_mapped_ff, basic_mapped_in;
   logic       selftest_mapped_ff, selftest_mapped_in;

   logic              s2_valid_ff;
   src_type           s2_src_ff, s2_src_in;
   logic [7:0]        s2_data_ff, s2_data_in;
   dev_type           s2_dev_ff, s2_dev_in;
   logic [4:0]        s2_off_ff, s2_off_in;
   logic              s2_dwr_ff, s2_dwr_in;
   logic              s2_trap_ff, s2_trap_in;

   logic              fire, room;
   logic              ram_we, os_we, basic_we;
   logic [RAM_AW-1:0] ram_addr;
   logic [OS_AW-1:0]  os_waddr, os_raddr;
   logic [BAS_AW-1:0] basic_waddr, basic_raddr;
   logic [OS_AW-1:0]  os_fixed_idx;
   logic [7:0]        pia_rdata;

   rsp_type           rsp_d;
   logic [$bits(rsp_type)-1:0] rsp_q;
   logic              rsp_full;
   logic [RSP_CW-1:0] rsp_count;

   // credit: stored responses plus the one in flight must fit
   assign room = ((RSP_CW+1)'(rsp_count) + (RSP_CW+1)'(s2_valid_ff))
                 < (RSP_CW+1)'(RSP_FIFO_DEPTH);
   assign fire     = cmd_valid && room && !clear_ff;
   assign cmd_pop  = fire;
   assign clearing = clear_ff;

   assign os_fixed_idx = OS_AW'(cmd.address - ADDR_OS_FIXED);

   // RAM clearing sweep after reset
   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end
   end

   always_comb begin
      case (pia_reg_type'(cmd.address[1:0]))
         PIA_PORT_A: pia_rdata = port_a_ctl_ff[PIA_CTL_DATA_BIT] ? cmd.stick_bits
                                                                 : port_a_dir_ff;
         PIA_PORT_B: begin
            if (!port_b_ctl_ff[PIA_CTL_DATA_BIT]) begin
               pia_rdata = port_b_dir_ff;
            end else begin
               pia_rdata = cfg.banked_model ? port_b_out_ff : BYTE_ONES;
            end
         end
         PIA_CTL_A:  pia_rdata = port_a_ctl_ff;
         default:    pia_rdata = port_b_ctl_ff;
      endcase
   end

   always_comb begin
      ram_we             = 1'b0;
      os_we              = 1'b0;
      basic_we           = 1'b0;
      ram_addr           = cmd.address;
      os_waddr           = cmd.address[OS_AW-1:0];
      os_raddr           = cmd.address[OS_AW-1:0];
      basic_waddr        = BAS_AW'(cmd.address - 16'(OS_ROM_DEPTH));
      basic_raddr        = cmd.address[BAS_AW-1:0];
      s2_src_in          = SRC_CONST;
      s2_data_in         = '0;
      s2_dev_in          = DEV_INTERNAL;
      s2_off_in          = '0;
      s2_dwr_in          = 1'b0;
      s2_trap_in         = 1'b0;
      port_b_out_in      = port_b_out_ff;
      port_a_dir_in      = port_a_dir_ff;
      port_b_dir_in      = port_b_dir_ff;
      port_a_ctl_in      = port_a_ctl_ff;
      port_b_ctl_in      = port_b_ctl_ff;
      os_mapped_in       = os_mapped_ff;
      basic_mapped_in    = basic_mapped_ff;
      selftest_mapped_in = selftest_mapped_ff;

      case (cmd.kind)
         REQ_ROM_LOAD: begin
            if (cmd.load_os) begin
               os_we = 1'b1;
            end else if (cmd.load_basic) begin
               basic_we = 1'b1;
            end
         end
         REQ_DMA_RD: begin
            if (cmd.io_win) begin
               s2_src_in = SRC_RAM;
            end else if (!cfg.banked_model) begin
               if (cmd.region == RG_HIGH) begin
                  s2_src_in = SRC_OS;
                  os_raddr  = os_fixed_idx;
               end else begin
                  s2_src_in = SRC_RAM;
               end
            end else if (os_mapped_ff &&
                         (cmd.region == RG_C000 || cmd.region == RG_HIGH)) begin
               s2_src_in = SRC_OS;
            end else if (basic_mapped_ff && cmd.basic_win) begin
               s2_src_in = SRC_BASIC;
            end else begin
               s2_src_in = SRC_RAM;
            end
         end
         REQ_CPU_RD: begin
            if (cmd.vec_hit && os_mapped_ff) begin
               s2_data_in = RTS_OPCODE;
               s2_trap_in = 1'b1;
            end else begin
               case (cmd.region)
                  RG_LOW: begin
                     if (cfg.banked_model && basic_mapped_ff && cmd.basic_win) begin
                        s2_src_in = SRC_BASIC;
                     end else if (selftest_mapped_ff && cmd.selftest_win) begin
                        // self-test window shows OS image 1000-17FF
                        s2_src_in = SRC_OS;
                     end else begin
                        s2_src_in = SRC_RAM;
                     end
                  end
                  RG_HIGH: begin
                     if (!cfg.banked_model) begin
                        s2_src_in = SRC_OS;
                        os_raddr  = os_fixed_idx;
                     end else begin
                        s2_src_in = os_mapped_ff ? SRC_OS : SRC_RAM;
                     end
                  end
                  RG_C000: begin
                     if (cfg.banked_model) begin
                        s2_src_in = os_mapped_ff ? SRC_OS : SRC_RAM;
                     end else begin
                        s2_data_in = BYTE_ONES;
                     end
                  end
                  RG_VIDEO: begin
                     s2_dev_in = DEV_VIDEO;
                     s2_off_in = cmd.offset;
                  end
                  RG_SOUND: begin
                     s2_dev_in = DEV_SOUND;
                     s2_off_in = cmd.offset;
                  end
                  RG_DISPLAY: begin
                     s2_dev_in = DEV_DISPLAY;
                     s2_off_in = cmd.offset;
                  end
                  RG_PIA:  s2_data_in = pia_rdata;
                  default: s2_data_in = BYTE_ONES;
               endcase
            end
         end
         REQ_CPU_WR: begin
            case (cmd.region)
               RG_LOW: ram_we = 1'b1;
               RG_HIGH, RG_C000: begin
                  // RAM under ROM takes the write only with the OS banked out
                  ram_we = cfg.banked_model && !os_mapped_ff;
               end
               RG_VIDEO: begin
                  s2_dev_in = DEV_VIDEO;
                  s2_off_in = cmd.offset;
                  s2_dwr_in = 1'b1;
               end
               RG_SOUND: begin
                  s2_dev_in = DEV_SOUND;
                  s2_off_in = cmd.offset;
                  s2_dwr_in = 1'b1;
               end
               RG_DISPLAY: begin
                  s2_dev_in = DEV_DISPLAY;
                  s2_off_in = cmd.offset;
                  s2_dwr_in = 1'b1;
               end
               RG_PIA: begin
                  // port A output latch drives nothing here, so a data write
                  // to port A has no visible effect
                  case (pia_reg_type'(cmd.address[1:0]))
                     PIA_PORT_A: begin
                        if (!port_a_ctl_ff[PIA_CTL_DATA_BIT]) begin
                           port_a_dir_in = cmd.write_data;
                        end
                     end
                     PIA_PORT_B: begin
                        if (port_b_ctl_ff[PIA_CTL_DATA_BIT]) begin
                           port_b_out_in = cmd.write_data;
                           if (cfg.banked_model) begin
                              os_mapped_in       = cmd.write_data[PB_OS_BIT];
                              basic_mapped_in    = cfg.basic_present &&
                                                   !cmd.write_data[PB_BASIC_BIT];
                              selftest_mapped_in = !cmd.write_data[PB_SELFTEST_BIT];
                           end
                        end else begin
                           port_b_dir_in = cmd.write_data;
                        end
                     end
                     PIA_CTL_A: port_a_ctl_in = cmd.write_data;
                     default:   port_b_ctl_in = cmd.write_data;
                  endcase
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff           <= 1'b1;
         clear_addr_ff      <= '0;
         port_b_out_ff      <= BYTE_ONES;
         port_a_dir_ff      <= '0;
         port_b_dir_ff      <= '0;
         port_a_ctl_ff      <= '0;
         port_b_ctl_ff      <= '0;
         os_mapped_ff       <= 1'b1;
         basic_mapped_ff    <= 1'b0;
         selftest_mapped_ff <= 1'b0;
         s2_valid_ff        <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
         s2_valid_ff   <= fire;
         if (fire) begin
            port_b_out_ff      <= port_b_out_in;
            port_a_dir_ff      <= port_a_dir_in;
            port_b_dir_ff      <= port_b_dir_in;
            port_a_ctl_ff      <= port_a_ctl_in;
            port_b_ctl_ff      <= port_b_ctl_in;
            os_mapped_ff       <= os_mapped_in;
            basic_mapped_ff    <= basic_mapped_in;
            selftest_mapped_ff <= selftest_mapped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s2_src_ff  <= s2_src_in;
         s2_data_ff <= s2_data_in;
         s2_dev_ff  <= s2_dev_in;
         s2_off_ff  <= s2_off_in;
         s2_dwr_ff  <= s2_dwr_in;
         s2_trap_ff <= s2_trap_in;
      end
   end

   // main RAM: one write port shared with the clearing sweep, one read port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         main_ram_ff[clear_addr_ff] <= '0;
      end else if (fire && ram_we) begin
         main_ram_ff[ram_addr] <= cmd.write_data;
      end
      ram_q_ff <= main_ram_ff[ram_addr];
   end

   always_ff @(posedge clock) begin
      if (fire && os_we) begin
         os_rom_ff[os_waddr] <= cmd.write_data;
      end
      os_q_ff <= os_rom_ff[os_raddr];
   end

   always_ff @(posedge clock) begin
      if (fire && basic_we) begin
         basic_rom_ff[basic_waddr] <= cmd.write_data;
      end
      basic_q_ff <= basic_rom_ff[basic_raddr];
   end

   always_comb begin
      rsp_d.device_select = s2_dev_ff;
      rsp_d.device_offset = s2_off_ff;
      rsp_d.device_write  = s2_dwr_ff;
      rsp_d.serial_trap   = s2_trap_ff;
      case (s2_src_ff)
         SRC_RAM:   rsp_d.read_data = ram_q_ff;
         SRC_OS:    rsp_d.read_data = os_q_ff;
         SRC_BASIC: rsp_d.read_data = basic_q_ff;
         default:   rsp_d.read_data = s2_data_ff;
      endcase
   end

   bmd_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s2_valid_ff),
      .push_data (rsp_d),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_q),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp = rsp_type'(rsp_q);

   // the credit check must keep the response queue from overflowing
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> !rsp_full)
      else $error("response pushed into a full queue");

   // nothing executes while RAM is being swept
   a_no_fire_while_clear: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !fire)
      else $error("command executed during RAM clear");

   // an executed command reaches the response stage on the next cycle
   a_fire_to_s2: assert property (@(posedge clock) disable iff (reset)
      fire |=> s2_valid_ff)
      else $error("executed command lost before response stage");

   // a trapped fetch answers with the constant opcode, never a memory byte
   a_trap_const: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_trap_ff) |-> (s2_src_ff == SRC_CONST && !s2_dwr_ff))
      else $error("serial trap took data from memory");

endmodule

[rtl/banked_memory_decoder_with_pia.sv]
// Top level of the banked memory decoder: configuration registers and the
// front/back pair. Uses bmd_pkg, bmd_front and bmd_back.
//
// Usage:
//   Requests enter like a queue write: present req_* and raise push; the
//   beat is taken on a clock edge with push high and full low. Results leave
//   like a queue read: while empty is low the oldest result is on rsp_*,
//   and pop high on a clock edge takes it. Every request, loads included,
//   yields exactly one result beat, in request order.
//   A request passes through the command queue, the execute stage and the
//   result queue before it shows on rsp_*. Throughput: one request per clock
//   sustained while pop keeps up and no RAM sweep runs; the RAM has one write
//   port and one read port, and the result queue holds four entries.
//   Stalls: if pop stays low the result queue fills, the back end stops,
//   the two-entry command queue fills and full rises; no beat is dropped.
//   Reset (synchronous, active high): PIA and banking state return to their
//   defaults, config returns to banked model with no BASIC, and the 64K RAM
//   is cleared by a sweep over all 65536 addresses, with full held high.
//   csr_* writes are taken at any time, also during the sweep; change
//   them only while no request is in flight.
module banked_memory_decoder_with_pia #(
   parameter int OS_ROM_DEPTH    = bmd_pkg::OS_ROM_DEPTH_DEF,
   parameter int BASIC_ROM_DEPTH = bmd_pkg::BASIC_ROM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic [15:0] req_fetch_pc,
   input  logic [7:0]  req_stick_bits,
   // result side
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_read_data,
   output logic [1:0]  rsp_device_select,
   output logic [4:0]  rsp_device_offset,
   output logic        rsp_device_write,
   output logic        rsp_serial_trap,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic        csr_wdata
);
   import bmd_pkg::*;

   logic    banked_model_ff, banked_model_in;
   logic    basic_present_ff, basic_present_in;
   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_valid, cmd_pop;
   logic    clearing;
   rsp_type rsp;

   // config register writes
   always_comb begin
      banked_model_in  = banked_model_ff;
      basic_present_in = basic_present_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_BANKED_MODEL: banked_model_in  = csr_wdata;
            default:          basic_present_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         banked_model_ff  <= 1'b1;
         basic_present_ff <= 1'b0;
      end else begin
         banked_model_ff  <= banked_model_in;
         basic_present_ff <= basic_present_in;
      end
   end

   assign cfg.banked_model  = banked_model_ff;
   assign cfg.basic_present = basic_present_ff;

   // front: classify and queue requests; held off during the RAM sweep
   bmd_front #(
      .OS_ROM_DEPTH    (OS_ROM_DEPTH),
      .BASIC_ROM_DEPTH (BASIC_ROM_DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_type       (req_type),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .req_fetch_pc   (req_fetch_pc),
      .req_stick_bits (req_stick_bits),
      .hold           (clearing),
      .cmd            (cmd),
      .cmd_valid      (cmd_valid),
      .cmd_pop        (cmd_pop)
   );

   // back: memories, PIA, banking and the result queue
   bmd_back #(
      .OS_ROM_DEPTH    (OS_ROM_DEPTH),
      .BASIC_ROM_DEPTH (BASIC_ROM_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp       (rsp),
      .rsp_empty (empty),
      .rsp_pop   (pop)
   );

   assign rsp_read_data     = rsp.read_data;
   assign rsp_device_select = rsp.device_select;
   assign rsp_device_offset = rsp.device_offset;
   assign rsp_device_write  = rsp.device_write;
   assign rsp_serial_trap   = rsp.serial_trap;

endmodule

[tb/banked_memory_decoder_with_pia_tb.sv]
// Self-checking testbench for banked_memory_decoder_with_pia: a directed opening,
// then random bus traffic over several map settings, checked against an in-bench predictor.
// Depends on bmd_pkg and the banked_memory_decoder_with_pia RTL only.
module banked_memory_decoder_with_pia_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bmd_pkg::*;

   // one bus request as it travels on the req_* ports
   typedef struct packed {
      req_kind_type kind;
      logic [15:0]  addr;
      logic [7:0]   wdata;
      logic [15:0]  pc;
      logic [7:0]   sticks;
   } bus_req_type;

   // a line of the opening script; want is used only when typed is set
   typedef struct packed {
      bus_req_type req;
      logic        typed;
      rsp_type     want;
   } script_row_type;

   localparam rsp_type QUIET = '0;
   localparam int PHASE_COUNT  = 5;
   localparam int PHASE_ITEMS  = 320;
   localparam int HOLD_AT      = 500;   // result count at which the receiver backs off
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 8;

   // map settings walked by the random phases, extremes included
   localparam cfg_type PHASE_CFG [PHASE_COUNT] = '{
      '{1'b1, 1'b1}, '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b1, 1'b0}, '{1'b1, 1'b1}
   };

   // windows where reads land on ROM bytes; each spans 16 addresses
   localparam logic [15:0] ROM_HOT_SPOTS [9] = '{
      16'h5000, 16'h57F0, 16'hA000, 16'hBFF0, 16'hC000,
      16'hCFF0, 16'hD800, 16'hE450, 16'hFFF0
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_type = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_write_data = '0;
   logic [15:0] req_fetch_pc = '0;
   logic [7:0]  req_stick_bits = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [1:0]  rsp_device_select;
   logic [4:0]  rsp_device_offset;
   logic        rsp_device_write;
   logic        rsp_serial_trap;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic        csr_wdata = 1'b0;

   banked_memory_decoder_with_pia uut (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_type          (req_type),
      .req_address       (req_address),
      .req_write_data    (req_write_data),
      .req_fetch_pc      (req_fetch_pc),
      .req_stick_bits    (req_stick_bits),
      .empty             (empty),
      .pop               (pop),
      .rsp_read_data     (rsp_read_data),
      .rsp_device_select (rsp_device_select),
      .rsp_device_offset (rsp_device_offset),
      .rsp_device_write  (rsp_device_write),
      .rsp_serial_trap   (rsp_serial_trap),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Shadow of the decoder state. It starts at the post-reset values since
   // reset is applied exactly once; RAM is all zero after the clearing sweep.
   // ---------------------------------------------------------------------
   bit [7:0] ram_img   [65536];
   bit [7:0] os_img    [OS_ROM_DEPTH_DEF];
   bit [7:0] basic_img [BASIC_ROM_DEPTH_DEF];
   bit       os_loaded    [OS_ROM_DEPTH_DEF];
   bit       basic_loaded [BASIC_ROM_DEPTH_DEF];
   logic [7:0] pa_out = 8'hFF, pb_out = 8'hFF;
   logic [7:0] pa_dir = '0, pb_dir = '0, pa_ctl = '0, pb_ctl = '0;
   logic       os_on = 1'b1, basic_on = 1'b0, selftest_on = 1'b0;
   cfg_type    map_cfg = '{1'b1, 1'b0};

   rsp_type owed_results [$];   // expected result beats, oldest first
   int      errors = 0;
   bit      send_burst = 1'b0;

   function automatic logic [7:0] pia_peek(input logic [1:0] sel, input logic [7:0] sticks);
      case (pia_reg_type'(sel))
         PIA_PORT_A: return pa_ctl[PIA_CTL_DATA_BIT] ? sticks : pa_dir;
         PIA_PORT_B: begin
            if (!pb_ctl[PIA_CTL_DATA_BIT]) return pb_dir;
            return map_cfg.banked_model ? pb_out : BYTE_ONES;
         end
         PIA_CTL_A:  return pa_ctl;
         default:    return pb_ctl;
      endcase
   endfunction

   // Work out the result beat of one request from the current shadow state.
   // src/idx tell which store the read byte comes from, so callers can keep
   // reads off ROM bytes that were never loaded.
   function automatic rsp_type decode_access(input bus_req_type r, output src_type src,
                                             output logic [15:0] idx);
      rsp_type     o;
      logic [15:0] a;
      logic        banked;
      o = QUIET;
      src = SRC_CONST;
      idx = '0;
      a = r.addr;
      banked = map_cfg.banked_model;
      case (r.kind)
         REQ_CPU_RD: begin
            if (a == SERIAL_VECTOR && r.pc == SERIAL_RET_PC && os_on) begin
               o.read_data = RTS_OPCODE;
               o.serial_trap = 1'b1;
            end else if (a < 16'hC000) begin
               if (banked && basic_on && a >= 16'hA000) begin
                  src = SRC_BASIC;
                  idx = a - 16'hA000;
               end else if (selftest_on && a >= 16'h5000 && a < 16'h5800) begin
                  src = SRC_OS;
                  idx = 16'h1000 + (a - 16'h5000);
               end else begin
                  src = SRC_RAM;
               end
            end else if (!banked && a >= ADDR_OS_FIXED) begin
               src = SRC_OS;
               idx = a - ADDR_OS_FIXED;
            end else if (banked && (a < 16'hD000 || a >= ADDR_OS_FIXED)) begin
               src = os_on ? SRC_OS : SRC_RAM;
               idx = a - 16'hC000;
            end else if (a[15:8] == 8'hD0) begin
               o.device_select = DEV_VIDEO;
               o.device_offset = a[4:0];
            end else if (a[15:8] == 8'hD2) begin
               o.device_select = DEV_SOUND;
               o.device_offset = {1'b0, a[3:0]};
            end else if (a[15:8] == 8'hD3) begin
               o.read_data = pia_peek(a[1:0], r.sticks);
            end else if (a[15:8] == 8'hD4) begin
               o.device_select = DEV_DISPLAY;
               o.device_offset = {1'b0, a[3:0]};
            end else begin
               o.read_data = BYTE_ONES;
            end
         end
         REQ_DMA_RD: begin
            // hardware pages always read RAM for dma; no self-test window here
            src = SRC_RAM;
            if (a >= 16'hD000 && a < ADDR_OS_FIXED) begin
               src = SRC_RAM;
            end else if (!banked) begin
               if (a >= ADDR_OS_FIXED) begin
                  src = SRC_OS;
                  idx = a - ADDR_OS_FIXED;
               end
            end else if (os_on && ((a >= 16'hC000 && a < 16'hD000) || a >= ADDR_OS_FIXED)) begin
               src = SRC_OS;
               idx = a - 16'hC000;
            end else if (basic_on && a >= 16'hA000 && a < 16'hC000) begin
               src = SRC_BASIC;
               idx = a - 16'hA000;
            end
         end
         REQ_CPU_WR: begin
            if (a >= 16'hC000 && !(a >= ADDR_OS_FIXED || (banked && a < 16'hD000))) begin
               if (a[15:8] == 8'hD0) begin
                  o.device_select = DEV_VIDEO;
                  o.device_offset = a[4:0];
                  o.device_write = 1'b1;
               end else if (a[15:8] == 8'hD2) begin
                  o.device_select = DEV_SOUND;
                  o.device_offset = {1'b0, a[3:0]};
                  o.device_write = 1'b1;
               end else if (a[15:8] == 8'hD4) begin
                  o.device_select = DEV_DISPLAY;
                  o.device_offset = {1'b0, a[3:0]};
                  o.device_write = 1'b1;
               end
            end
         end
         default: ;
      endcase
      case (src)
         SRC_RAM:   o.read_data = ram_img[a];
         SRC_OS:    o.read_data = os_img[idx];
         SRC_BASIC: o.read_data = basic_img[idx];
         default: ;
      endcase
      return o;
   endfunction

   // Advance the shadow state by one request: loads, RAM writes, PIA writes.
   task automatic apply_access(input bus_req_type r);
      logic [15:0] a;
      a = r.addr;
      if (r.kind == REQ_ROM_LOAD) begin
         if (a < 16'(OS_ROM_DEPTH_DEF)) begin
            os_img[a] = r.wdata;
            os_loaded[a] = 1'b1;
         end else if (a < 16'(OS_ROM_DEPTH_DEF + BASIC_ROM_DEPTH_DEF)) begin
            basic_img[a - 16'(OS_ROM_DEPTH_DEF)] = r.wdata;
            basic_loaded[a - 16'(OS_ROM_DEPTH_DEF)] = 1'b1;
         end
      end else if (r.kind == REQ_CPU_WR) begin
         if (a < 16'hC000) begin
            ram_img[a] = r.wdata;
         end else if (a >= ADDR_OS_FIXED || (map_cfg.banked_model && a < 16'hD000)) begin
            // ROM space writes fall through to RAM only with the OS banked out
            if (map_cfg.banked_model && !os_on) ram_img[a] = r.wdata;
         end else if (a[15:8] == 8'hD3) begin
            case (pia_reg_type'(a[1:0]))
               PIA_PORT_A: begin
                  if (pa_ctl[PIA_CTL_DATA_BIT]) pa_out = r.wdata;
                  else pa_dir = r.wdata;
               end
               PIA_PORT_B: begin
                  if (pb_ctl[PIA_CTL_DATA_BIT]) begin
                     pb_out = r.wdata;
                     if (map_cfg.banked_model) begin
                        os_on = r.wdata[PB_OS_BIT];
                        basic_on = map_cfg.basic_present && !r.wdata[PB_BASIC_BIT];
                        selftest_on = !r.wdata[PB_SELFTEST_BIT];
                     end
                  end else begin
                     pb_dir = r.wdata;
                  end
               end
               PIA_CTL_A: pa_ctl = r.wdata;
               default:   pb_ctl = r.wdata;
            endcase
         end
      end
   endtask

   // Predict, record the expectation, then offer the beat until it is taken.
   task automatic issue_access(input bus_req_type r, input logic typed, input rsp_type want);
      rsp_type     pred;
      src_type     src;
      logic [15:0] idx;
      int          gap;
      pred = decode_access(r, src, idx);
      apply_access(r);
      if (typed) pred = want;
      owed_results = {owed_results, pred};
      if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
      gap = send_burst ? 0 : int'($urandom_range(0, 19));
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_type <= r.kind;
      req_address <= r.addr;
      req_write_data <= r.wdata;
      req_fetch_pc <= r.pc;
      req_stick_bits <= r.sticks;
      @(posedge clock);
      while (full) @(posedge clock);
   endtask

   // Draw one random request. Reads that would hit a ROM byte never loaded
   // turn into the load of that byte, so ROM windows fill on demand.
   task automatic make_random(output bus_req_type r);
      int unsigned pick;
      bus_req_type probe;
      rsp_type     unused;
      src_type     src;
      logic [15:0] idx;
      pick = $urandom_range(0, 99);
      if (pick < 35) r.kind = REQ_CPU_RD;
      else if (pick < 65) r.kind = REQ_CPU_WR;
      else if (pick < 80) r.kind = REQ_DMA_RD;
      else r.kind = REQ_ROM_LOAD;
      r.wdata = 8'($urandom);
      r.pc = 16'($urandom);
      r.sticks = 8'($urandom);
      case ($urandom_range(0, 7))
         0, 1:    r.addr = 16'($urandom);
         2, 3:    r.addr = ROM_HOT_SPOTS[$urandom_range(0, 8)] + 16'($urandom_range(0, 15));
         4:       r.addr = {5'b11010, 11'($urandom)};
         5:       r.addr = {8'hD3, 8'($urandom)};
         6:       r.addr = 16'($urandom_range(0, 63));
         default: r.addr = 16'h5000 + 16'($urandom_range(0, 16'h07FF));
      endcase
      // steer a third of the writes at the PIA so banking keeps moving
      if (r.kind == REQ_CPU_WR && $urandom_range(0, 2) == 0) r.addr = {8'hD3, 8'($urandom)};
      if (r.addr == SERIAL_VECTOR && $urandom_range(0, 1) == 1) r.pc = SERIAL_RET_PC;
      probe = r;
      if (r.kind == REQ_ROM_LOAD) probe.kind = REQ_CPU_RD;
      unused = decode_access(probe, src, idx);
      if (r.kind == REQ_ROM_LOAD) begin
         // aim the load at the byte a CPU read of that address would see
         if (src == SRC_OS) r.addr = idx;
         else if (src == SRC_BASIC) r.addr = 16'(OS_ROM_DEPTH_DEF) + idx;
      end else if ((src == SRC_OS && !os_loaded[idx]) ||
                   (src == SRC_BASIC && !basic_loaded[idx])) begin
         r.kind = REQ_ROM_LOAD;
         r.addr = (src == SRC_OS) ? idx : 16'(OS_ROM_DEPTH_DEF) + idx;
      end
   endtask

   // Drop push and hold until every owed beat has come back.
   task automatic settle();
      push <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both map registers on idle cycles and mirror them in the shadow.
   task automatic configure(input cfg_type c);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_BANKED_MODEL;
      csr_wdata <= c.banked_model;
      @(posedge clock);
      csr_index <= CSR_BASIC_PRESENT;
      csr_wdata <= c.basic_present;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      map_cfg = c;
   endtask

   // Compare the beat just popped against the oldest expectation.
   task automatic check_beat();
      rsp_type want;
      if (owed_results.size() == 0) begin
         $error("result beat with nothing owed: read_data %h device_select %0d",
                rsp_read_data, rsp_device_select);
         errors++;
      end else begin
         want = owed_results.pop_front();
         if (rsp_read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, rsp_read_data);
            errors++;
         end
         if (rsp_device_select !== want.device_select) begin
            $error("device_select: expected %0d, got %0d", want.device_select,
                   rsp_device_select);
            errors++;
         end
         if (rsp_device_offset !== want.device_offset) begin
            $error("device_offset: expected %h, got %h", want.device_offset,
                   rsp_device_offset);
            errors++;
         end
         if (rsp_device_write !== want.device_write) begin
            $error("device_write: expected %b, got %b", want.device_write, rsp_device_write);
            errors++;
         end
         if (rsp_serial_trap !== want.serial_trap) begin
            $error("serial_trap: expected %b, got %b", want.serial_trap, rsp_serial_trap);
            errors++;
         end
      end
   endtask

   // Opening script, run on the reset map: banked model, OS in, no BASIC.
   // Rows with typed set carry their result; the rest go to the predictor.
   script_row_type opening_script [$] = '{
      // RAM reads back zero after the clearing sweep
      '{'{REQ_CPU_RD,   16'h0000, 8'h00, 16'h0000, 8'hFF}, 1'b1, QUIET},
      // load the ROM bytes the script reads; last one is past both images
      '{'{REQ_ROM_LOAD, 16'h3FFF, 8'hA5, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_ROM_LOAD, 16'h1000, 8'h3C, 16'hFFFF, 8'h00}, 1'b1, QUIET},
      '{'{REQ_ROM_LOAD, 16'h2459, 8'h77, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_ROM_LOAD, 16'hFFFF, 8'h5A, 16'h0000, 8'h00}, 1'b1, QUIET},
      // top of the OS image
      '{'{REQ_CPU_RD,   16'hFFFF, 8'h00, 16'h0000, 8'h00}, 1'b1,
        '{8'hA5, DEV_INTERNAL, 5'd0, 1'b0, 1'b0}},
      // serial vector fetch is answered with RTS
      '{'{REQ_CPU_RD,   16'hE459, 8'h00, 16'hE45A, 8'h00}, 1'b1,
        '{RTS_OPCODE, DEV_INTERNAL, 5'd0, 1'b0, 1'b1}},
      // same address, other PC: plain OS byte
      '{'{REQ_CPU_RD,   16'hE459, 8'h00, 16'hE459, 8'h00}, 1'b0, QUIET},
      '{'{REQ_CPU_WR,   16'h1234, 8'h5A, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_CPU_RD,   16'h1234, 8'h00, 16'h0000, 8'h00}, 1'b0, QUIET},
      // forwarded device accesses
      '{'{REQ_CPU_WR,   16'hD01F, 8'hFF, 16'h0000, 8'h00}, 1'b1,
        '{8'h00, DEV_VIDEO, 5'h1F, 1'b1, 1'b0}},
      '{'{REQ_CPU_RD,   16'hD20F, 8'h00, 16'h0000, 8'h00}, 1'b1,
        '{8'h00, DEV_SOUND, 5'h0F, 1'b0, 1'b0}},
      '{'{REQ_CPU_WR,   16'hD4EA, 8'h00, 16'h0000, 8'h00}, 1'b1,
        '{8'h00, DEV_DISPLAY, 5'h0A, 1'b1, 1'b0}},
      // unmapped hardware page
      '{'{REQ_CPU_RD,   16'hD100, 8'h00, 16'h0000, 8'h00}, 1'b1,
        '{BYTE_ONES, DEV_INTERNAL, 5'd0, 1'b0, 1'b0}},
      // PIA: direction register first, then sticks once port A is in data mode
      '{'{REQ_CPU_RD,   16'hD300, 8'h00, 16'h0000, 8'h5A}, 1'b0, QUIET},
      '{'{REQ_CPU_WR,   16'hD302, 8'h04, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_CPU_RD,   16'hD300, 8'h00, 16'h0000, 8'hA5}, 1'b0, QUIET},
      // bank the OS out and the self-test window in through port B
      '{'{REQ_CPU_WR,   16'hD303, 8'h04, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_CPU_WR,   16'hD301, 8'h7C, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_CPU_RD,   16'hD301, 8'h00, 16'h0000, 8'h00}, 1'b0, QUIET},
      '{'{REQ_CPU_RD,   16'h5000, 8'h00, 16'h0000, 8'h00}, 1'b0, QUIET},
      // with the OS out, ROM space writes and reads hit RAM
      '{'{REQ_CPU_WR,   16'hFFFF, 8'h11, 16'h0000, 8'h00}, 1'b1, QUIET},
      '{'{REQ_CPU_RD,   16'hFFFF, 8'h00, 16'h0000, 8'h00}, 1'b0, QUIET},
      // no trap while the OS is banked out
      '{'{REQ_CPU_RD,   16'hE459, 8'h00, 16'hE45A, 8'h00}, 1'b0, QUIET},
      '{'{REQ_DMA_RD,   16'hD000, 8'h00, 16'h0000, 8'h00}, 1'b0, QUIET},
      // restore the default banks
      '{'{REQ_CPU_WR,   16'hD301, 8'hFF, 16'h0000, 8'h00}, 1'b1, QUIET}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: stall a random number of cycles per beat, with stretches
   // of back-to-back pops, and one long hold-off that backs the block up
   // until full rises while the sender keeps offering.
   initial begin : result_side
      int stall;
      int taken;
      bit burst;
      taken = 0;
      burst = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) burst = !burst;
         stall = burst ? 0 : int'($urandom_range(0, 19));
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         check_beat();
         taken++;
      end
   end

   // Stimulus: reset, opening script, then random phases over the map settings.
   initial begin : request_side
      bus_req_type r;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // the RAM clearing sweep keeps full high; the first beat simply waits on it
      foreach (opening_script[i])
         issue_access(opening_script[i].req, opening_script[i].typed, opening_script[i].want);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         configure(PHASE_CFG[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            make_random(r);
            issue_access(r, 1'b0, QUIET);
         end
      end
      settle();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: covers the clearing sweep and the slowest legal traffic many times over.
   initial begin : watchdog
      #8_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[banked_memory_decoder_with_pia.f]
rtl/bmd_pkg.sv
rtl/bmd_fifo.sv
rtl/bmd_front.sv
rtl/bmd_back.sv
rtl/banked_memory_decoder_with_pia.sv
tb/banked_memory_decoder_with_pia_tb.sv
